// ===== hw/rtl/ukl_pkg.sv =====
// ukl_pkg: shared types and constants for the unordered key list
// holds the word structs, opcode and state enums, and the scan token control struct
// no dependencies
package ukl_pkg;

    // fixed field widths of the channel words
    localparam int unsigned IN_KEY_WIDTH = 32;
    localparam int unsigned POS_WIDTH    = 4;
    localparam int unsigned FILL_WIDTH   = 5;
    localparam int unsigned CAP_WIDTH    = 5;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2
    } t_opcode;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPORT
    } t_state;

    // input word
    typedef struct packed {
        logic [1:0]                     opcode;
        logic signed [IN_KEY_WIDTH-1:0] key;
    } t_in_word;

    // output word
    typedef struct packed {
        logic                  ok;
        logic [POS_WIDTH-1:0]  position;
        logic [FILL_WIDTH-1:0] fill;
    } t_out_word;

    // control part of the search token walking the cell row
    typedef struct packed {
        logic valid;
        logic found;
    } t_scan_ctl;

endpackage

// ===== hw/rtl/ukl_cell.sv =====
// ukl_cell: one slot of the key row, stores one key and compares it with the passing token
// the token (control, key, matched slot, last key) is registered and handed to the next cell
// depends on ukl_pkg
module ukl_cell #(
    parameter int unsigned INDEX      = 0,
    parameter int unsigned KEY_WIDTH  = 32,
    parameter int unsigned SLOT_WIDTH = 4,
    parameter int unsigned CNT_WIDTH  = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CNT_WIDTH-1:0]  i_count,
    input  logic                  i_wr_sel,
    input  logic [KEY_WIDTH-1:0]  i_wr_data,
    input  ukl_pkg::t_scan_ctl    i_ctl,
    input  logic [KEY_WIDTH-1:0]  i_key,
    input  logic [SLOT_WIDTH-1:0] i_slot,
    input  logic [KEY_WIDTH-1:0]  i_last,
    output ukl_pkg::t_scan_ctl    o_ctl,
    output logic [KEY_WIDTH-1:0]  o_key,
    output logic [SLOT_WIDTH-1:0] o_slot,
    output logic [KEY_WIDTH-1:0]  o_last
);
    import ukl_pkg::*;

    logic [KEY_WIDTH-1:0]  r_entry;
    t_scan_ctl             r_ctl;
    t_scan_ctl             n_ctl;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [SLOT_WIDTH-1:0] r_slot;
    logic [SLOT_WIDTH-1:0] n_slot;
    logic [KEY_WIDTH-1:0]  r_last;
    logic [KEY_WIDTH-1:0]  n_last;
    logic                  occupied;
    logic                  is_last;
    logic                  hit;

    // slot is in use when it lies below the fill count
    assign occupied = CNT_WIDTH'(INDEX) < i_count;
    assign is_last  = CNT_WIDTH'(INDEX + 1) == i_count;
    assign hit      = i_ctl.valid && occupied && !i_ctl.found && (r_entry == i_key);

    // token update: first match wins, last occupied slot donates its key
    always_comb begin
        n_ctl.valid = i_ctl.valid;
        n_ctl.found = i_ctl.found || hit;
        n_slot      = hit ? SLOT_WIDTH'(INDEX) : i_slot;
        n_last      = (i_ctl.valid && is_last) ? r_entry : i_last;
    end

    // stored key
    always_ff @(posedge i_clk) begin
        if (i_wr_sel) begin
            r_entry <= i_wr_data;
        end
    end

    // token control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // token payload registers
    always_ff @(posedge i_clk) begin
        r_key  <= i_key;
        r_slot <= n_slot;
        r_last <= n_last;
    end

    assign o_ctl  = r_ctl;
    assign o_key  = r_key;
    assign o_slot = r_slot;
    assign o_last = r_last;

endmodule

// ===== hw/rtl/unordered_key_list.sv =====
// unordered_key_list: top level, controller, capacity register and the row of key cells
// depends on ukl_pkg and ukl_cell
//
//   channel  | direction | handshake                | word
//   ---------+-----------+--------------------------+-----------------------------
//   in       | into      | i_in_valid / o_in_stall  | i_in_word  (opcode, key)
//   out      | out of    | o_out_valid / i_out_stall| o_out_word (ok, position, fill)
//   cfg      | into      | i_cfg_we                 | i_cfg_data (capacity)
//
// one word at a time: insert and unused opcodes go from accept straight to the report state,
// search and remove pass through the scan state while the token walks all DEPTH cells
// the result waits in an output register; a new word is taken once it is loaded there
// a stall on the out channel holds the finished result and the table update
// reset (synchronous, active low) empties the table and sets capacity to 16
module unordered_key_list #(
    parameter int unsigned DEPTH     = 16,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ukl_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ukl_pkg::t_out_word              o_out_word,
    input  logic                            i_cfg_we,
    input  logic [ukl_pkg::CAP_WIDTH-1:0]   i_cfg_data
);
    import ukl_pkg::*;

    localparam int unsigned SW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;
    localparam int unsigned KS   = (KEY_WIDTH < IN_KEY_WIDTH) ? KEY_WIDTH : IN_KEY_WIDTH;
    localparam int unsigned PS   = (SW < POS_WIDTH) ? SW : POS_WIDTH;
    localparam int unsigned FS   = (CW < FILL_WIDTH) ? CW : FILL_WIDTH;

    t_state                r_state;
    t_state                n_state;
    logic [1:0]            r_op;
    logic [KEY_WIDTH-1:0]  r_key;
    logic                  r_ok;
    logic [SW-1:0]         r_slot;
    logic [KEY_WIDTH-1:0]  r_last;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CAP_WIDTH-1:0]  r_cap;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic                  accept;
    logic                  commit;
    logic                  launch;
    logic                  room;
    logic [CMPW-1:0]       cnt_ext;
    logic [CMPW-1:0]       cap_ext;
    logic [KEY_WIDTH-1:0]  in_key;
    logic [POS_WIDTH-1:0]  pos_ext;
    logic [FILL_WIDTH-1:0] fill_ext;
    logic                  wr_en;
    logic [SW-1:0]         wr_idx;
    logic [KEY_WIDTH-1:0]  wr_data;

    t_scan_ctl             w_ctl  [DEPTH+1];
    logic [KEY_WIDTH-1:0]  w_key  [DEPTH+1];
    logic [SW-1:0]         w_slot [DEPTH+1];
    logic [KEY_WIDTH-1:0]  w_last [DEPTH+1];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = launch ? ST_SCAN : ST_REPORT;
                end
            end
            ST_SCAN: begin
                if (w_ctl[DEPTH].valid) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        accept     = i_in_valid && (r_state == ST_IDLE);
        launch     = (i_in_word.opcode == OP_SEARCH) || (i_in_word.opcode == OP_REMOVE);
        commit     = (r_state == ST_REPORT) && (!r_out_valid || !i_out_stall);
    end

    // room check against min(capacity, DEPTH)
    always_comb begin
        cnt_ext = CMPW'(r_count);
        cap_ext = CMPW'(r_cap);
        room    = (cnt_ext < cap_ext) && (r_count < CW'(DEPTH));
    end

    // input key to stored width, zero-extended when the store is wider
    always_comb begin
        in_key         = '0;
        in_key[KS-1:0] = i_in_word.key[KS-1:0];
    end

    // table write and new count at commit
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_slot;
        wr_data = r_last;
        n_count = r_count;
        case (r_op)
            OP_INSERT: begin
                wr_en   = commit && r_ok;
                wr_idx  = r_count[SW-1:0];
                wr_data = r_key;
                n_count = r_ok ? r_count + CW'(1) : r_count;
            end
            OP_REMOVE: begin
                wr_en   = commit && r_ok;
                n_count = r_ok ? r_count - CW'(1) : r_count;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // result field widths
    always_comb begin
        pos_ext            = '0;
        pos_ext[PS-1:0]    = r_slot[PS-1:0];
        fill_ext           = '0;
        fill_ext[FS-1:0]   = n_count[FS-1:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // word registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_in_word.opcode;
            r_key <= in_key;
            if (i_in_word.opcode == OP_INSERT) begin
                r_ok   <= room;
                r_slot <= room ? r_count[SW-1:0] : '0;
            end else begin
                r_ok   <= 1'b0;
                r_slot <= '0;
            end
        end else if (r_state == ST_SCAN && w_ctl[DEPTH].valid) begin
            r_ok   <= w_ctl[DEPTH].found;
            r_slot <= w_ctl[DEPTH].found ? w_slot[DEPTH] : '0;
            r_last <= w_last[DEPTH];
        end
        if (commit) begin
            r_out_word.ok       <= r_ok;
            r_out_word.position <= pos_ext;
            r_out_word.fill     <= fill_ext;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // token entering the row
    assign w_ctl[0].valid = accept && launch;
    assign w_ctl[0].found = 1'b0;
    assign w_key[0]       = in_key;
    assign w_slot[0]      = '0;
    assign w_last[0]      = '0;

    // row of key cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ukl_cell #(
            .INDEX      (g),
            .KEY_WIDTH  (KEY_WIDTH),
            .SLOT_WIDTH (SW),
            .CNT_WIDTH  (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_count   (r_count),
            .i_wr_sel  (wr_en && (wr_idx == SW'(g))),
            .i_wr_data (wr_data),
            .i_ctl     (w_ctl[g]),
            .i_key     (w_key[g]),
            .i_slot    (w_slot[g]),
            .i_last    (w_last[g]),
            .o_ctl     (w_ctl[g+1]),
            .o_key     (w_key[g+1]),
            .o_slot    (w_slot[g+1]),
            .o_last    (w_last[g+1])
        );
    end

`ifndef SYNTHESIS
    // fill count never exceeds the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    // a token only leaves the row while the controller waits for it
    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[DEPTH].valid |-> (r_state == ST_SCAN))
        else $error("scan token outside scan state");

    // count changes only when a result is committed
    a_count_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !commit |=> $stable(r_count))
        else $error("count changed without commit");

    // a refused or missed operation reports position zero
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.ok) |-> (o_out_word.position == '0))
        else $error("nonzero position on failed operation");
`endif

endmodule

// ===== test/unordered_key_list_test.sv =====
// unordered_key_list_test: self-checking bench for the unordered key list
// a directed table of words, then random phases at several capacities
// depends on ukl_pkg and unordered_key_list
module unordered_key_list_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ukl_pkg::*;

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int unsigned NUM_PHASES  = 9;
    localparam int unsigned PHASE_WORDS = 125;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned NUM_ROWS    = 23;

    // opcode the block answers without touching the table
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic {
        ROW_WORD,
        ROW_CAP
    } t_row_kind;

    // one line of the directed table; capacity rows carry the value in key
    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] op;
        logic [31:0] key;
        logic       known;
        t_out_word  want;
    } t_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_word   in_word = '0;
    logic       out_stall = 1'b0;
    logic       cfg_we = 1'b0;
    logic [CAP_WIDTH-1:0] cfg_data = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;

    // shadow of the table, its fill count and the capacity register
    logic [31:0] table_keys [TABLE_DEPTH];
    int unsigned table_fill = 0;
    logic [CAP_WIDTH-1:0] table_cap = CAP_RESET;

    t_out_word   pending_results [$];
    int unsigned failures = 0;
    int unsigned cycle_count = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    // extremes, first-match, last-slot remove, zero and low capacity
    t_row dir_rows [NUM_ROWS] = '{
        '{ROW_WORD, OP_SEARCH, 32'h00000000, 1'b1, '{1'b0, 4'd0, 5'd0}},
        '{ROW_WORD, OP_REMOVE, 32'h00000005, 1'b1, '{1'b0, 4'd0, 5'd0}},
        '{ROW_WORD, OP_UNUSED, 32'h00000000, 1'b1, '{1'b0, 4'd0, 5'd0}},
        '{ROW_WORD, OP_INSERT, 32'h80000000, 1'b1, '{1'b1, 4'd0, 5'd1}},
        '{ROW_WORD, OP_INSERT, 32'h7FFFFFFF, 1'b1, '{1'b1, 4'd1, 5'd2}},
        '{ROW_WORD, OP_INSERT, 32'h00000000, 1'b0, '0},
        '{ROW_WORD, OP_INSERT, 32'hFFFFFFFF, 1'b0, '0},
        '{ROW_WORD, OP_INSERT, 32'h7FFFFFFF, 1'b0, '0},
        '{ROW_WORD, OP_SEARCH, 32'h7FFFFFFF, 1'b1, '{1'b1, 4'd1, 5'd5}},
        '{ROW_WORD, OP_SEARCH, 32'h80000000, 1'b1, '{1'b1, 4'd0, 5'd5}},
        '{ROW_WORD, OP_SEARCH, 32'h00000001, 1'b1, '{1'b0, 4'd0, 5'd5}},
        '{ROW_WORD, OP_SEARCH, 32'hFFFFFFFE, 1'b1, '{1'b0, 4'd0, 5'd5}},
        '{ROW_WORD, OP_UNUSED, 32'hFFFFFFFF, 1'b1, '{1'b0, 4'd0, 5'd5}},
        '{ROW_WORD, OP_REMOVE, 32'h80000000, 1'b1, '{1'b1, 4'd0, 5'd4}},
        '{ROW_WORD, OP_SEARCH, 32'h7FFFFFFF, 1'b0, '0},
        '{ROW_WORD, OP_REMOVE, 32'hFFFFFFFF, 1'b1, '{1'b1, 4'd3, 5'd3}},
        '{ROW_WORD, OP_REMOVE, 32'h12345678, 1'b1, '{1'b0, 4'd0, 5'd3}},
        '{ROW_CAP,  OP_INSERT, 32'd0,        1'b0, '0},
        '{ROW_WORD, OP_INSERT, 32'h00000005, 1'b1, '{1'b0, 4'd0, 5'd3}},
        '{ROW_CAP,  OP_INSERT, 32'd3,        1'b0, '0},
        '{ROW_WORD, OP_INSERT, 32'h00000006, 1'b1, '{1'b0, 4'd0, 5'd3}},
        '{ROW_WORD, OP_REMOVE, 32'h00000000, 1'b1, '{1'b1, 4'd2, 5'd2}},
        '{ROW_CAP,  OP_INSERT, 32'd31,       1'b0, '0}
    };

    int unsigned phase_caps [NUM_PHASES] = '{16, 1, 31, 0, 5, 16, 17, 2, 12};

    unordered_key_list dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    // 8 ns clock
    initial begin
        forever #4 clk = ~clk;
    end

    // run-time limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("unordered_key_list_test NOT OK");
            $finish;
        end
    end

    // table behavior: apply one word to the shadow state, return its result
    function automatic t_out_word apply_op(t_in_word w);
        t_out_word   res;
        int unsigned eff_cap;
        int unsigned slot;
        bit          hit;
        res = '0;
        hit = 1'b0;
        slot = 0;
        eff_cap = (table_cap > TABLE_DEPTH) ? TABLE_DEPTH : table_cap;
        for (int unsigned i = 0; i < table_fill; i++) begin
            if (!hit && table_keys[i] == w.key) begin
                hit = 1'b1;
                slot = i;
            end
        end
        case (w.opcode)
            OP_INSERT: begin
                if (table_fill < eff_cap) begin
                    table_keys[table_fill] = w.key;
                    res.ok = 1'b1;
                    res.position = table_fill[POS_WIDTH-1:0];
                    table_fill++;
                end
            end
            OP_SEARCH: begin
                if (hit) begin
                    res.ok = 1'b1;
                    res.position = slot[POS_WIDTH-1:0];
                end
            end
            OP_REMOVE: begin
                if (hit) begin
                    table_keys[slot] = table_keys[table_fill-1];
                    table_fill--;
                    res.ok = 1'b1;
                    res.position = slot[POS_WIDTH-1:0];
                end
            end
            default: ;
        endcase
        res.fill = table_fill[FILL_WIDTH-1:0];
        return res;
    endfunction

    // offer one word, record its result on accept, then maybe leave a gap
    task automatic send_word(t_in_word w, bit use_given, t_out_word given);
        t_out_word   pred;
        int unsigned gap;
        int unsigned r;
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (!(in_valid && !o_in_stall));
        pred = apply_op(w);
        pending_results.push_back(use_given ? given : pred);
        r = $urandom_range(99, 0);
        if (quiet || r < 55) gap = 0;
        else if (r < 88) gap = $urandom_range(3, 1);
        else if (r < 98) gap = $urandom_range(10, 4);
        else gap = $urandom_range(60, 20);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // capacity write once every result is back and the block is idle
    task automatic write_capacity(logic [CAP_WIDTH-1:0] cap);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= cap;
        table_cap = cap;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // receiver: random stalls, long hold on request, none when quiet
    initial begin : result_sink
        int unsigned run_left;
        run_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
                run_left = $urandom_range(8, 1);
            end else if (quiet) begin
                out_stall <= 1'b0;
                run_left = 0;
            end else if (run_left > 0) begin
                run_left--;
            end else if (out_stall) begin
                out_stall <= 1'b0;
                run_left = $urandom_range(8, 0);
            end else begin
                out_stall <= 1'b1;
                run_left = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10)
                                                       : $urandom_range(2, 0);
            end
        end
    end

    // compare each accepted result word with the oldest pending one
    always @(posedge clk) begin : result_check
        t_out_word want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none pending, expected nothing, actual %p",
                         $time, o_out_word);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.ok !== want.ok) begin
                    $display("%0t: ok mismatch, expected %0d, actual %0d",
                             $time, want.ok, o_out_word.ok);
                    failures++;
                end
                if (o_out_word.position !== want.position) begin
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, want.position, o_out_word.position);
                    failures++;
                end
                if (o_out_word.fill !== want.fill) begin
                    $display("%0t: fill mismatch, expected %0d, actual %0d",
                             $time, want.fill, o_out_word.fill);
                    failures++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_in_word    w;
        logic [31:0] key_pool [6];
        logic [31:0] base;
        int unsigned r;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int unsigned n = 0; n < NUM_ROWS; n++) begin
            if (dir_rows[n].kind == ROW_CAP) begin
                write_capacity(dir_rows[n].key[CAP_WIDTH-1:0]);
            end else begin
                w.opcode = dir_rows[n].op;
                w.key = dir_rows[n].key;
                send_word(w, dir_rows[n].known, dir_rows[n].want);
            end
        end

        // random phases over a small key pool so lookups mostly hit
        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            write_capacity(phase_caps[p][CAP_WIDTH-1:0]);
            quiet = (p == 5);
            if (p == 2) hold_req = 1'b1;
            base = $urandom;
            key_pool[0] = base;
            key_pool[1] = base ^ (32'h1 << $urandom_range(31, 0));
            key_pool[2] = $urandom_range(1, 0) ? 32'h80000000 : $urandom;
            key_pool[3] = 32'h7FFFFFFF;
            key_pool[4] = $urandom;
            key_pool[5] = $urandom_range(1, 0) ? 32'hFFFFFFFF : 32'h00000000;
            for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
                // sender waits for the pipe to drain once mid-phase
                if (p == 4 && n == 60) begin
                    in_valid <= 1'b0;
                    while (pending_results.size() != 0) @(negedge clk);
                    @(negedge clk);
                end
                r = $urandom_range(99, 0);
                if (r < 38) w.opcode = OP_INSERT;
                else if (r < 68) w.opcode = OP_SEARCH;
                else if (r < 95) w.opcode = OP_REMOVE;
                else w.opcode = OP_UNUSED;
                w.key = ($urandom_range(99, 0) < 85) ? key_pool[$urandom_range(5, 0)]
                                                     : $urandom;
                send_word(w, 1'b0, '0);
            end
        end
        quiet = 1'b0;

        // drain, then watch for stray results
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (failures == 0) begin
            $display("unordered_key_list_test OK");
        end else begin
            $display("unordered_key_list_test NOT OK");
        end
        $finish;
    end

endmodule
